>>> rtl/lmor_pkg.sv
package lmor_pkg;

  localparam int unsigned ScreenSize = 8;
  localparam int unsigned GlyphCols  = 3;
  localparam int unsigned ColW       = $clog2(ScreenSize);
  localparam int unsigned CntW       = $clog2(ScreenSize + 1);

  localparam logic KindRect  = 1'b0;
  localparam logic KindDigit = 1'b1;

  typedef logic [ScreenSize-1:0] col_bits_t;
  typedef logic [GlyphCols-1:0][ScreenSize-1:0] glyph_t;

  typedef struct packed {
    logic        draw;
    logic        kind;
    logic [7:0]  pos_x;
    logic [3:0]  rect_width;
    col_bits_t   row_mask;
    glyph_t      glyph;
    logic        load;
    logic        shift;
  } cell_ctl_t;

  function automatic glyph_t font_glyph(input logic [3:0] digit);
    glyph_t g;
    unique case (digit)
      4'h0: g = {8'h6C, 8'h82, 8'h6C};
      4'h1: g = {8'hFE, 8'h00, 8'h00};
      4'h2: g = {8'h62, 8'h92, 8'h8C};
      4'h3: g = {8'h6C, 8'h92, 8'h92};
      4'h4: g = {8'hFC, 8'h10, 8'hE0};
      4'h5: g = {8'h8C, 8'h92, 8'h62};
      4'h6: g = {8'h8C, 8'h92, 8'h7C};
      4'h7: g = {8'h7C, 8'h80, 8'h80};
      4'h8: g = {8'h6C, 8'h92, 8'h6C};
      4'h9: g = {8'h7C, 8'h92, 8'h60};
      4'hA: g = {8'h7E, 8'h90, 8'h7E};
      4'hB: g = {8'h0C, 8'h12, 8'h6C};
      4'hC: g = {8'h82, 8'h82, 8'h7C};
      4'hD: g = {8'h6C, 8'h12, 8'h0C};
      4'hE: g = {8'h92, 8'h92, 8'h6C};
      4'hF: g = {8'h90, 8'h90, 8'h6C};
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

>>> rtl/lmor_if.sv
interface lmor_obj_if;
  logic       valid;
  logic       ready;
  logic       visible;
  logic       kind;
  logic [7:0] pos_x;
  logic [7:0] pos_y;
  logic [3:0] rect_width;
  logic [3:0] rect_height;
  logic [3:0] digit;
  logic       frame_end;

  modport source (output valid, visible, kind, pos_x, pos_y, rect_width, rect_height, digit,
                  frame_end, input ready);
  modport sink (input valid, visible, kind, pos_x, pos_y, rect_width, rect_height, digit,
                frame_end, output ready);
endinterface

interface lmor_col_if;
  logic       valid;
  logic       ready;
  logic [2:0] column_index;
  logic [7:0] column_bits;
  logic       last;

  modport source (output valid, column_index, column_bits, last, input ready);
  modport sink (input valid, column_index, column_bits, last, output ready);
endinterface

>>> rtl/led_matrix_object_rasterizer_top.sv
// Channel | Dir | Payload
// obj_i   | in  | visible, kind, pos_x, pos_y, rect_width, rect_height, digit, frame_end
// col_o   | out | column_index, column_bits, last
// One object per cycle unless a frame-end object is held back; all eight column cells draw in parallel.
// A frame-end object is copied into the readout chain, which shifts one column per cycle while col_o is ready.
// A frame-end object waits until the last column of the previous readout is accepted.
// Drawing continues during readout. Reset clears the frame store and the readout chain.
module led_matrix_object_rasterizer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  lmor_obj_if.sink    obj_i,
  lmor_col_if.source  col_o
);

  localparam int unsigned N = lmor_pkg::ScreenSize;

  logic [lmor_pkg::CntW-1:0] rd_cnt_q, rd_cnt_d;
  logic                      rd_free, in_acc, out_acc, on_screen;
  lmor_pkg::col_bits_t       row_mask;
  lmor_pkg::cell_ctl_t       ctl;
  lmor_pkg::col_bits_t       chain [N+1];

  assign rd_free = (rd_cnt_q == '0) || ((rd_cnt_q == lmor_pkg::CntW'(1)) && col_o.ready);
  assign obj_i.ready = !obj_i.frame_end || rd_free;
  assign in_acc  = obj_i.valid && obj_i.ready;
  assign out_acc = col_o.valid && col_o.ready;

  assign on_screen = (obj_i.pos_x[7] || (obj_i.pos_x[6:3] == 4'd0))
                  && (obj_i.pos_y[7] || (obj_i.pos_y[6:3] == 4'd0));

  always_comb begin
    logic signed [9:0] dy;
    row_mask = '0;
    for (int r = 0; r < N; r++) begin
      dy = $signed(10'(r)) - $signed({{2{obj_i.pos_y[7]}}, obj_i.pos_y});
      row_mask[N-1-r] = !dy[9] && (dy < $signed({6'b0, obj_i.rect_height}));
    end
  end

  always_comb begin
    ctl.draw       = in_acc && obj_i.visible && on_screen;
    ctl.kind       = obj_i.kind;
    ctl.pos_x      = obj_i.pos_x;
    ctl.rect_width = obj_i.rect_width;
    ctl.row_mask   = row_mask;
    ctl.glyph      = lmor_pkg::font_glyph(obj_i.digit);
    ctl.load       = in_acc && obj_i.frame_end;
    ctl.shift      = out_acc;
  end

  assign chain[N] = '0;

  for (genvar c = 0; c < N; c++) begin : g_cell
    lmor_cell #(.COL(c)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .next_i (chain[c+1]),
      .out_o  (chain[c])
    );
  end

  always_comb begin
    rd_cnt_d = rd_cnt_q;
    if (ctl.load) rd_cnt_d = lmor_pkg::CntW'(N);
    else if (out_acc) rd_cnt_d = rd_cnt_q - lmor_pkg::CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_cnt_q <= '0;
    end else begin
      rd_cnt_q <= rd_cnt_d;
    end
  end

  assign col_o.valid        = (rd_cnt_q != '0);
  assign col_o.column_bits  = chain[0];
  assign col_o.column_index = lmor_pkg::ColW'(lmor_pkg::CntW'(N) - rd_cnt_q);
  assign col_o.last         = (rd_cnt_q == lmor_pkg::CntW'(1));

  a_first_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(col_o.valid) |-> (col_o.column_index == '0))
    else $error("readout did not start at column 0");

  a_last_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_o.valid && col_o.last) |-> (col_o.column_index == lmor_pkg::ColW'(N - 1)))
    else $error("last mark off the final column");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && obj_i.frame_end) |-> rd_free)
    else $error("frame loaded over a running readout");

  a_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && obj_i.frame_end) |=> (rd_cnt_q == lmor_pkg::CntW'(N)))
    else $error("readout count not loaded");

endmodule

>>> rtl/lmor_cell.sv
module lmor_cell #(
  parameter int unsigned COL = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lmor_pkg::cell_ctl_t ctl_i,
  input  lmor_pkg::col_bits_t next_i,
  output lmor_pkg::col_bits_t out_o
);

  localparam logic [lmor_pkg::ColW-1:0] ColIdx = lmor_pkg::ColW'(COL);

  lmor_pkg::col_bits_t store_q, store_d;
  lmor_pkg::col_bits_t out_q, out_d;
  lmor_pkg::col_bits_t paint, drawn;
  logic signed [9:0]   dx;
  logic                rect_hit;

  // offset of this column from the object's left edge
  assign dx = $signed({{(10 - lmor_pkg::ColW){1'b0}}, ColIdx})
            - $signed({{2{ctl_i.pos_x[7]}}, ctl_i.pos_x});
  assign rect_hit = !dx[9] && (dx < $signed({6'b0, ctl_i.rect_width}));

  always_comb begin
    paint = '0;
    if (ctl_i.draw) begin
      if (ctl_i.kind == lmor_pkg::KindDigit) begin
        if (dx == 10'sd0) paint = ctl_i.glyph[0];
        else if (dx == 10'sd1) paint = ctl_i.glyph[1];
        else if (dx == 10'sd2) paint = ctl_i.glyph[2];
      end else if (rect_hit) begin
        paint = ctl_i.row_mask;
      end
    end
  end

  assign drawn = store_q | paint;

  always_comb begin
    store_d = store_q;
    out_d   = out_q;
    if (ctl_i.load) begin
      store_d = '0;
      out_d   = drawn;
    end else begin
      store_d = drawn;
      if (ctl_i.shift) out_d = next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q <= '0;
      out_q   <= '0;
    end else begin
      store_q <= store_d;
      out_q   <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

>>> verif/led_matrix_object_rasterizer_top_tb.sv
module led_matrix_object_rasterizer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Scr        = int'(lmor_pkg::ScreenSize);
  localparam int GlyphW     = int'(lmor_pkg::GlyphCols);
  localparam int StallLimit = 4000;

  typedef struct {
    logic       visible;
    logic       kind;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [3:0] rect_width;
    logic [3:0] rect_height;
    logic [3:0] digit;
    logic       frame_end;
    int         gap;
    bit         drain;
  } obj_item_t;

  typedef struct packed {
    logic [2:0] idx;
    logic [7:0] bits;
    logic       last;
  } column_t;

  logic clk_i;
  logic rst_ni;

  lmor_obj_if obj_bus ();
  lmor_col_if col_bus ();

  led_matrix_object_rasterizer_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .obj_i  (obj_bus),
    .col_o  (col_bus)
  );

  obj_item_t   obj_queue[$];
  column_t     col_expect[$];
  logic [7:0]  frame_model [Scr];
  int          errors;
  int          n_obj;
  int          n_frames;
  int          n_cols;
  int          n_digits;
  int          n_drains;
  int          idle_run;
  int          stall_cycles;
  int          burst_left;
  bit          quiet;
  logic [7:0]  rx_cyc;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int clip(int n, int lo, int hi);
    if (n < lo) return lo;
    if (n > hi) return hi;
    return n;
  endfunction

  // packed as {col0, col1, col2}
  function automatic logic [7:0] glyph_column(logic [3:0] d, int g);
    logic [23:0] font;
    case (d)
      4'h0: font = 24'h6C826C;
      4'h1: font = 24'h0000FE;
      4'h2: font = 24'h8C9262;
      4'h3: font = 24'h92926C;
      4'h4: font = 24'hE010FC;
      4'h5: font = 24'h62928C;
      4'h6: font = 24'h7C928C;
      4'h7: font = 24'h80807C;
      4'h8: font = 24'h6C926C;
      4'h9: font = 24'h60927C;
      4'hA: font = 24'h7E907E;
      4'hB: font = 24'h6C120C;
      4'hC: font = 24'h7C8282;
      4'hD: font = 24'h0C126C;
      4'hE: font = 24'h6C9292;
      default: font = 24'h6C9090;
    endcase
    return font[23-8*g -: 8];
  endfunction

  task automatic draw_object(obj_item_t o);
    int px;
    int py;
    int x0;
    int x1;
    int y0;
    int y1;
    int g;
    logic [7:0] mask;
    px = int'($signed(o.pos_x));
    py = int'($signed(o.pos_y));
    if (!o.visible || px > Scr - 1 || py > Scr - 1) return;
    x0 = clip(px, 0, Scr - 1);
    if (o.kind == lmor_pkg::KindDigit) begin
      x1 = clip(px + GlyphW, 0, Scr);
      for (int x = x0; x < x1; x++) begin
        g = x - px;
        if (g >= 0 && g < GlyphW) frame_model[x] |= glyph_column(o.digit, g);
      end
    end else begin
      x1 = clip(px + int'(o.rect_width), 0, Scr);
      y0 = clip(py, 0, Scr - 1);
      y1 = clip(py + int'(o.rect_height), 0, Scr);
      if (x1 > x0 && y1 > y0) begin
        mask = 8'(((32'd1 << (y1 - y0)) - 32'd1) << (Scr - y1));
        for (int x = x0; x < x1; x++) frame_model[x] |= mask;
      end
    end
  endtask

  task automatic push_obj(logic vis, logic kind, int px, int py, int w, int h, int d,
                          logic fe);
    obj_item_t it;
    it.visible     = vis;
    it.kind        = kind;
    it.pos_x       = 8'(px);
    it.pos_y       = 8'(py);
    it.rect_width  = 4'(w);
    it.rect_height = 4'(h);
    it.digit       = 4'(d);
    it.frame_end   = fe;
    it.drain       = 1'b0;
    if (quiet) begin
      it.gap = 0;
    end else if (burst_left <= 0) begin
      it.gap     = $urandom_range(1, 7);
      burst_left = $urandom_range(1, 8);
    end else begin
      it.gap = 0;
    end
    burst_left--;
    obj_queue.push_back(it);
  endtask

  function automatic int rand_coord();
    if ($urandom_range(0, 4) == 0) return int'($signed(8'($urandom)));
    return int'($urandom_range(0, 12)) - 4;
  endfunction

  task automatic flag_field(string what, int expv, int actv);
    errors++;
    if (errors <= 30)
      $display("%0t: column %s mismatch, expected %0h, actual %0h", $time, what, expv, actv);
  endtask

  // stimulus
  initial begin
    int nf;
    int pushed;
    int frame_no;
    rst_ni              = 1'b0;
    obj_bus.valid       = 1'b0;
    obj_bus.visible     = 1'b0;
    obj_bus.kind        = lmor_pkg::KindRect;
    obj_bus.pos_x       = '0;
    obj_bus.pos_y       = '0;
    obj_bus.rect_width  = '0;
    obj_bus.rect_height = '0;
    obj_bus.digit       = '0;
    obj_bus.frame_end   = 1'b0;
    col_bus.ready       = 1'b0;
    errors     = 0;
    burst_left = 0;
    quiet      = 1'b0;
    for (int i = 0; i < Scr; i++) frame_model[i] = '0;

    push_obj(1, lmor_pkg::KindRect, 0, 0, 8, 8, 0, 1);
    push_obj(1, lmor_pkg::KindRect, 2, 2, 0, 5, 0, 0);
    push_obj(1, lmor_pkg::KindRect, 3, 1, 4, 0, 0, 0);
    push_obj(1, lmor_pkg::KindRect, 5, 6, 15, 15, 0, 0);
    push_obj(1, lmor_pkg::KindRect, -3, -2, 6, 5, 0, 1);
    push_obj(1, lmor_pkg::KindRect, -128, -128, 15, 15, 0, 0);
    push_obj(1, lmor_pkg::KindRect, 8, 0, 4, 4, 0, 0);
    push_obj(1, lmor_pkg::KindRect, 0, 8, 4, 4, 0, 0);
    push_obj(1, lmor_pkg::KindRect, 127, 127, 15, 15, 0, 1);
    push_obj(0, lmor_pkg::KindRect, 0, 0, 8, 8, 0, 1);
    for (int d = 0; d < 16; d++) begin
      push_obj(1, lmor_pkg::KindDigit, (d % 11) - 3,
               (d == 5) ? 8 : (d == 12) ? 127 : (d % 2 == 1) ? d - 128 : d,
               d, 15 - d, d, (d % 4 == 3));
    end

    pushed   = 0;
    frame_no = 0;
    while (pushed < 76) begin
      quiet = (frame_no % 5 == 2);
      nf    = $urandom_range(1, 6);
      for (int k = 0; k < nf; k++) begin
        push_obj($urandom_range(0, 9) != 0, 1'($urandom), rand_coord(), rand_coord(),
                 ($urandom_range(0, 6) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 8),
                 ($urandom_range(0, 6) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 8),
                 $urandom_range(0, 15),
                 (k == nf - 1) || ($urandom_range(0, 19) == 0));
        if (k == 0 && (frame_no == 3 || $urandom_range(0, 7) == 0))
          obj_queue[$].drain = 1'b1;
      end
      pushed += nf;
      frame_no++;
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (obj_queue.size() != 0 || obj_bus.valid) @(negedge clk_i);
    while (col_expect.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (col_expect.size() != 0) begin
      errors++;
      $display("%0t: %0d columns never arrived", $time, col_expect.size());
    end
    $display("Drew %0d objects (%0d digits) over %0d frames, %0d pauses until drained,",
             n_obj, n_digits, n_frames, n_drains);
    $display("and compared %0d emitted columns; %0d errors.", n_cols, errors);
    if (errors == 0) begin
      $display("led_matrix_object_rasterizer_top verification clean");
    end else begin
      $display("led_matrix_object_rasterizer_top verification failed");
    end
    $finish;
  end

  // object driver
  always @(posedge clk_i or negedge rst_ni) begin : drv
    obj_item_t nxt;
    if (!rst_ni) begin
      obj_bus.valid       <= 1'b0;
      obj_bus.visible     <= 1'b0;
      obj_bus.kind        <= lmor_pkg::KindRect;
      obj_bus.pos_x       <= '0;
      obj_bus.pos_y       <= '0;
      obj_bus.rect_width  <= '0;
      obj_bus.rect_height <= '0;
      obj_bus.digit       <= '0;
      obj_bus.frame_end   <= 1'b0;
      idle_run            <= 0;
    end else if (!obj_bus.valid || obj_bus.ready) begin
      if (obj_queue.size() == 0) begin
        obj_bus.valid <= 1'b0;
      end else if (idle_run < obj_queue[0].gap) begin
        obj_bus.valid <= 1'b0;
        idle_run      <= idle_run + 1;
      end else if (obj_queue[0].drain && (obj_bus.valid || col_expect.size() != 0)) begin
        obj_bus.valid <= 1'b0;
      end else begin
        nxt = obj_queue.pop_front();
        if (nxt.drain) n_drains++;
        obj_bus.valid       <= 1'b1;
        obj_bus.visible     <= nxt.visible;
        obj_bus.kind        <= nxt.kind;
        obj_bus.pos_x       <= nxt.pos_x;
        obj_bus.pos_y       <= nxt.pos_y;
        obj_bus.rect_width  <= nxt.rect_width;
        obj_bus.rect_height <= nxt.rect_height;
        obj_bus.digit       <= nxt.digit;
        obj_bus.frame_end   <= nxt.frame_end;
        idle_run            <= 0;
      end
    end
  end

  // column sink stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_bus.ready <= 1'b0;
      rx_cyc        <= '0;
    end else begin
      rx_cyc <= rx_cyc + 8'd1;
      case (rx_cyc[7:6])
        2'd0: col_bus.ready <= 1'b1;
        2'd1: col_bus.ready <= ($urandom_range(0, 1) == 0);
        2'd2: col_bus.ready <= ($urandom_range(0, 4) == 0);
        default: col_bus.ready <= (rx_cyc[1:0] != 2'd0);
      endcase
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk_i) begin : mon
    obj_item_t seen;
    column_t   want;
    bit        moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (obj_bus.valid && obj_bus.ready) begin
        moved             = 1'b1;
        seen.visible      = obj_bus.visible;
        seen.kind         = obj_bus.kind;
        seen.pos_x        = obj_bus.pos_x;
        seen.pos_y        = obj_bus.pos_y;
        seen.rect_width   = obj_bus.rect_width;
        seen.rect_height  = obj_bus.rect_height;
        seen.digit        = obj_bus.digit;
        seen.frame_end    = obj_bus.frame_end;
        n_obj++;
        if (seen.kind == lmor_pkg::KindDigit) n_digits++;
        draw_object(seen);
        if (seen.frame_end) begin
          n_frames++;
          for (int i = 0; i < Scr; i++) begin
            col_expect.push_back(column_t'{3'(i), frame_model[i], 1'(i == Scr - 1)});
            frame_model[i] = '0;
          end
        end
      end
      if (col_bus.valid && col_bus.ready) begin
        moved = 1'b1;
        n_cols++;
        if (col_expect.size() == 0) begin
          errors++;
          if (errors <= 30)
            $display("%0t: unexpected column transaction, expected none, actual %0h/%0h/%0b",
                     $time, col_bus.column_index, col_bus.column_bits, col_bus.last);
        end else begin
          want = col_expect.pop_front();
          if (col_bus.column_index !== want.idx)
            flag_field("index", want.idx, col_bus.column_index);
          if (col_bus.column_bits !== want.bits)
            flag_field("bits", want.bits, col_bus.column_bits);
          if (col_bus.last !== want.last)
            flag_field("last", want.last, col_bus.last);
        end
      end
      if (moved) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, StallLimit);
        $display("led_matrix_object_rasterizer_top verification failed");
        $finish;
      end
    end
  end

endmodule

>>> led_matrix_object_rasterizer_top.f
rtl/lmor_pkg.sv
rtl/lmor_if.sv
rtl/lmor_cell.sv
rtl/led_matrix_object_rasterizer_top.sv
verif/led_matrix_object_rasterizer_top_tb.sv
